// ----- rtl/mrc_pkg.sv -----
// Shared types, constants and helper functions for the multimeter reading converter.
// Depends on nothing; the other files in rtl, mrc_div apart, refer to it by scoped names.
package mrc_pkg;

    localparam int ADC_BITS_DEF = 12;
    localparam int COUNT_W      = 12;
    localparam int SW_W         = 6;
    localparam int VREF_W       = 20;
    localparam int RATIO_W      = 8;
    localparam int PAR_W        = 24;
    localparam int MEAS_W       = 48;
    localparam int MAG_W        = 47;
    localparam int SUPPLY_W     = 32;
    localparam int RANGE_W      = 3;
    localparam int STATUS_W     = 2;
    localparam int GAIN_W       = 5;
    localparam int SCALE_W      = 18;
    localparam int DEN2_W       = 19;
    localparam int RX_W         = 52;
    localparam int PQ_W         = 40;
    localparam int DD_W         = 41;
    localparam int PROD_W       = 64;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam int DIV1_BPS = 4;
    localparam int DIV2_BPS = 4;
    localparam int DIV3_BPS = 2;

    localparam int TWO_Q16      = 131072;
    localparam int TWO_HALF_Q16 = 163840;

    localparam logic [MAG_W-1:0]   MAG_MAX   = '1;
    localparam logic [VREF_W-1:0]  VREF_RST  = 20'd78971;
    localparam logic [RATIO_W-1:0] RATIO_RST = 8'd13;
    localparam logic [PAR_W-1:0]   PAR_RST   = 24'd2000000;

    localparam logic [1:0] REG_VREF  = 2'd0;
    localparam logic [1:0] REG_RATIO = 2'd1;
    localparam logic [1:0] REG_PAR   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OPEN    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

    localparam logic [RANGE_W-1:0] RANGE_2V   = 3'd0;
    localparam logic [RANGE_W-1:0] RANGE_10V  = 3'd1;
    localparam logic [RANGE_W-1:0] RANGE_50V  = 3'd2;
    localparam logic [RANGE_W-1:0] RANGE_1K   = 3'd3;
    localparam logic [RANGE_W-1:0] RANGE_10K  = 3'd4;
    localparam logic [RANGE_W-1:0] RANGE_100K = 3'd5;
    localparam logic [RANGE_W-1:0] RANGE_1M   = 3'd6;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic               ref_zero;
    } front_side_t;

    typedef struct packed {
        logic [RANGE_W-1:0]  range;
        logic                ref_zero;
        logic                neg;
        logic                pole;
        logic [SUPPLY_W-1:0] supply;
        logic                sup_sat;
        logic [MAG_W-1:0]    vmag;
        logic                vsat;
    } mid_side_t;

    typedef struct packed {
        mid_side_t mid;
        logic      dd_zero;
        logic      ovf;
    } solve_side_t;

    function automatic logic [RANGE_W-1:0] pick_range(input logic [SW_W-1:0] sw);
        logic [RANGE_W-1:0] r;
        if (sw[0])      r = RANGE_2V;
        else if (sw[1]) r = RANGE_10V;
        else if (sw[2]) r = RANGE_50V;
        else if (sw[3]) r = RANGE_10K;
        else if (sw[4]) r = RANGE_100K;
        else if (sw[5]) r = RANGE_1M;
        else            r = RANGE_1K;
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] volt_gain(input logic [RANGE_W-1:0] r);
        logic [GAIN_W-1:0] g;
        case (r)
            RANGE_10V: g = 5'd5;
            RANGE_50V: g = 5'd25;
            default:   g = 5'd1;
        endcase
        return g;
    endfunction

    function automatic logic [SCALE_W-1:0] ohm_scale(input logic [RANGE_W-1:0] r);
        logic [SCALE_W-1:0] s;
        case (r)
            RANGE_10K:  s = 18'd2000;
            RANGE_100K: s = 18'd20000;
            RANGE_1M:   s = 18'd200000;
            default:    s = 18'd200;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/mrc_div.sv -----
// Pipelined restoring divider with several lanes sharing one divisor.
// Depends on nothing; sideband bits travel with each transaction.
module mrc_div #(
    parameter int LANES  = 1,
    parameter int DEN_W  = 12,
    parameter int QUO_W  = 40,
    parameter int BPS    = 4,
    parameter int SIDE_W = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [DEN_W-1:0]                in_den,
    input  logic [LANES-1:0][DEN_W-1:0]     in_rem,
    input  logic [LANES-1:0][QUO_W-1:0]     in_low,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [LANES-1:0][QUO_W-1:0]     out_quo,
    output logic [SIDE_W-1:0]               out_side
);

    localparam int STAGES = (QUO_W + BPS - 1) / BPS;

    logic [STAGES-1:0]              valid_reg;
    logic [STAGES:0]                en;
    logic [DEN_W-1:0]               den_reg  [STAGES];
    logic [LANES-1:0][DEN_W-1:0]    rem_reg  [STAGES];
    logic [LANES-1:0][QUO_W-1:0]    low_reg  [STAGES];
    logic [SIDE_W-1:0]              side_reg [STAGES];

    assign en[STAGES] = out_ready;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            logic                           src_valid;
            logic [DEN_W-1:0]               src_den;
            logic [LANES-1:0][DEN_W-1:0]    src_rem;
            logic [LANES-1:0][QUO_W-1:0]    src_low;
            logic [SIDE_W-1:0]              src_side;
            logic [LANES-1:0][DEN_W-1:0]    rem_next;
            logic [LANES-1:0][QUO_W-1:0]    low_next;
            logic [DEN_W:0]                 trial;

            if (s == 0)
            begin : g_head
                assign src_valid = in_valid;
                assign src_den   = in_den;
                assign src_rem   = in_rem;
                assign src_low   = in_low;
                assign src_side  = in_side;
            end
            else
            begin : g_body
                assign src_valid = valid_reg[s-1];
                assign src_den   = den_reg[s-1];
                assign src_rem   = rem_reg[s-1];
                assign src_low   = low_reg[s-1];
                assign src_side  = side_reg[s-1];
            end

            assign en[s] = !valid_reg[s] || en[s+1];

            always_comb
            begin
                rem_next = src_rem;
                low_next = src_low;
                trial    = '0;
                for (int l = 0; l < LANES; l++)
                begin
                    for (int j = 0; j < BPS; j++)
                    begin
                        if (s * BPS + j < QUO_W)
                        begin
                            trial = {rem_next[l], low_next[l][QUO_W-1]};
                            low_next[l] = {low_next[l][QUO_W-2:0], 1'b0};
                            if (trial >= {1'b0, src_den})
                            begin
                                trial = trial - {1'b0, src_den};
                                low_next[l][0] = 1'b1;
                            end
                            rem_next[l] = trial[DEN_W-1:0];
                        end
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    valid_reg[s] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    den_reg[s]  <= src_den;
                    rem_reg[s]  <= rem_next;
                    low_reg[s]  <= low_next;
                    side_reg[s] <= src_side;
                end
            end
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = low_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ----- rtl/mrc_front.sv -----
// Front stages: count masking, range pick and the calibration numerator products.
// Depends on mrc_pkg.
module mrc_front #(
    parameter int ADC_BITS = mrc_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mrc_pkg::COUNT_W-1:0]         raw_input_count,
    input  logic [mrc_pkg::COUNT_W-1:0]         raw_reference_count,
    input  logic [mrc_pkg::COUNT_W-1:0]         raw_supply_count,
    input  logic [mrc_pkg::SW_W-1:0]            range_switches,
    input  logic [mrc_pkg::VREF_W-1:0]          vref,
    input  logic [mrc_pkg::RATIO_W-1:0]         ratio,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [((ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W)-1:0] out_den,
    output logic [((ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W)
                  + mrc_pkg::VREF_W - 1:0]      out_vnum,
    output logic [((ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W)
                  + mrc_pkg::VREF_W + mrc_pkg::RATIO_W - 1:0] out_snum,
    output mrc_pkg::front_side_t                out_side
);

    localparam int CNT_W = (ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W;
    localparam int VN_W  = CNT_W + mrc_pkg::VREF_W;
    localparam int SN_W  = VN_W + mrc_pkg::RATIO_W;

    logic                           en1;
    logic                           en2;
    logic                           s1_valid_reg;
    logic                           s2_valid_reg;
    logic [CNT_W-1:0]               cref_reg;
    logic [VN_W-1:0]                in_prod_reg;
    logic [VN_W-1:0]                pwr_prod_reg;
    logic [mrc_pkg::RANGE_W-1:0]    range_reg;
    logic [VN_W-1:0]                in_prod_next;
    logic [VN_W-1:0]                pwr_prod_next;
    logic [CNT_W-1:0]               den_reg;
    logic [VN_W-1:0]                vnum_reg;
    logic [SN_W-1:0]                snum_reg;
    mrc_pkg::front_side_t           side_reg;
    logic [SN_W-1:0]                snum_next;

    assign en2 = !s2_valid_reg || out_ready;
    assign en1 = !s1_valid_reg || en2;

    assign in_prod_next  = VN_W'(raw_input_count[CNT_W-1:0]) * VN_W'(vref);
    assign pwr_prod_next = VN_W'(raw_supply_count[CNT_W-1:0]) * VN_W'(vref);
    assign snum_next     = SN_W'(pwr_prod_reg) * SN_W'(ratio);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            cref_reg     <= raw_reference_count[CNT_W-1:0];
            in_prod_reg  <= in_prod_next;
            pwr_prod_reg <= pwr_prod_next;
            range_reg    <= mrc_pkg::pick_range(range_switches);
        end
        if (en2)
        begin
            den_reg           <= cref_reg;
            vnum_reg          <= in_prod_reg;
            snum_reg          <= snum_next;
            side_reg.range    <= range_reg;
            side_reg.ref_zero <= (cref_reg == '0);
        end
    end

    assign in_ready  = en1;
    assign out_valid = s2_valid_reg;
    assign out_den   = den_reg;
    assign out_vnum  = vnum_reg;
    assign out_snum  = snum_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/mrc_mid.sv -----
// Middle stage: input voltage, supply saturation, voltage-range scaling and the
// divider numerator and denominator for resistance. Depends on mrc_pkg.
module mrc_mid #(
    parameter int ADC_BITS = mrc_pkg::ADC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0][((ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W)
                       + mrc_pkg::VREF_W + mrc_pkg::RATIO_W - 1:0] in_quo,
    input  mrc_pkg::front_side_t                in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mrc_pkg::DEN2_W-1:0]          out_den,
    output logic [mrc_pkg::RX_W-1:0]            out_num,
    output mrc_pkg::mid_side_t                  out_side
);

    localparam int CNT_W = (ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W;
    localparam int VN_W  = CNT_W + mrc_pkg::VREF_W;
    localparam int SN_W  = VN_W + mrc_pkg::RATIO_W;
    localparam int V_W   = VN_W + 2;
    localparam int D_W   = V_W + 1;
    localparam int VM_W  = V_W + mrc_pkg::GAIN_W;
    localparam int N2_W  = 2 * mrc_pkg::SCALE_W;

    logic                               en;
    logic                               valid_reg;
    logic signed [V_W-1:0]              v;
    logic [V_W-1:0]                     vmag;
    logic [VM_W-1:0]                    vm_full;
    logic signed [D_W-1:0]              den;
    logic [N2_W-1:0]                    num2;
    logic [SN_W-1:0]                    sq;
    mrc_pkg::mid_side_t                 side_next;
    mrc_pkg::mid_side_t                 side_reg;
    logic [mrc_pkg::DEN2_W-1:0]         den_reg;
    logic [mrc_pkg::RX_W-1:0]           num_reg;

    assign en = !valid_reg || out_ready;

    always_comb
    begin
        v       = $signed({1'b0, in_quo[0][VN_W-1:0], 1'b0}) - $signed(V_W'(mrc_pkg::TWO_Q16));
        vmag    = v[V_W-1] ? V_W'(-v) : V_W'(v);
        vm_full = VM_W'(vmag) * VM_W'(mrc_pkg::volt_gain(in_side.range));
        den     = $signed(D_W'(mrc_pkg::TWO_HALF_Q16)) - D_W'(v);
        num2    = N2_W'(vmag[mrc_pkg::SCALE_W-1:0]) * N2_W'(mrc_pkg::ohm_scale(in_side.range));
        sq      = in_quo[1];

        side_next.range    = in_side.range;
        side_next.ref_zero = in_side.ref_zero;
        side_next.neg      = v[V_W-1];
        side_next.pole     = den[D_W-1] || (den == '0);
        side_next.sup_sat  = |sq[SN_W-1:mrc_pkg::SUPPLY_W];
        side_next.supply   = side_next.sup_sat ? '1 : sq[mrc_pkg::SUPPLY_W-1:0];
        side_next.vsat     = 64'(vm_full) > 64'(mrc_pkg::MAG_MAX);
        side_next.vmag     = side_next.vsat ? mrc_pkg::MAG_MAX : mrc_pkg::MAG_W'(vm_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            den_reg  <= den[mrc_pkg::DEN2_W-1:0];
            num_reg  <= {num2, 16'd0};
        end
    end

    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_num   = num_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/mrc_solve.sv -----
// Parallel-resistor removal setup: pole check, difference term and the wide
// product split into partial products. Depends on mrc_pkg.
module mrc_solve (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mrc_pkg::RX_W-1:0]    in_rx,
    input  mrc_pkg::mid_side_t          in_side,
    input  logic [mrc_pkg::PAR_W-1:0]   par,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mrc_pkg::DD_W-1:0]    out_den,
    output logic [mrc_pkg::DD_W-1:0]    out_rem,
    output logic [mrc_pkg::MAG_W-1:0]   out_low,
    output mrc_pkg::solve_side_t        out_side
);

    localparam int HALF_W = mrc_pkg::PQ_W / 2;
    localparam int PP_W   = HALF_W + mrc_pkg::PAR_W;
    localparam int HI_W   = mrc_pkg::PROD_W - (mrc_pkg::MAG_W - 16);

    logic                           en1;
    logic                           en2;
    logic                           s1_valid_reg;
    logic                           s2_valid_reg;
    logic [mrc_pkg::PQ_W-1:0]       pq;
    logic [mrc_pkg::PQ_W-1:0]       rx40;
    logic [mrc_pkg::DD_W-1:0]       dd_next;
    mrc_pkg::mid_side_t             mside_next;
    mrc_pkg::mid_side_t             mside_reg;
    logic [mrc_pkg::DD_W-1:0]       dd_reg;
    logic [PP_W-1:0]                pp_lo_reg;
    logic [PP_W-1:0]                pp_hi_reg;
    logic [mrc_pkg::PROD_W-1:0]     prod;
    logic [HI_W-1:0]                high;
    mrc_pkg::solve_side_t           side_next;
    mrc_pkg::solve_side_t           side_reg;
    logic [mrc_pkg::DD_W-1:0]       den_reg;
    logic [mrc_pkg::DD_W-1:0]       rem_reg;
    logic [mrc_pkg::MAG_W-1:0]      low_reg;

    assign en2 = !s2_valid_reg || out_ready;
    assign en1 = !s1_valid_reg || en2;

    always_comb
    begin
        pq      = {par, 16'd0};
        rx40    = in_rx[mrc_pkg::PQ_W-1:0];
        dd_next = in_side.neg ? (mrc_pkg::DD_W'(pq) + mrc_pkg::DD_W'(rx40))
                              : (mrc_pkg::DD_W'(pq) - mrc_pkg::DD_W'(rx40));
        mside_next      = in_side;
        mside_next.pole = in_side.pole || (!in_side.neg && (in_rx >= mrc_pkg::RX_W'(pq)));
    end

    always_comb
    begin
        prod = (mrc_pkg::PROD_W'(pp_hi_reg) << HALF_W) + mrc_pkg::PROD_W'(pp_lo_reg);
        high = prod[mrc_pkg::PROD_W-1:mrc_pkg::MAG_W-16];
        side_next.mid     = mside_reg;
        side_next.dd_zero = (dd_reg == '0);
        side_next.ovf     = !side_next.dd_zero && (mrc_pkg::DD_W'(high) >= dd_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mside_reg <= mside_next;
            dd_reg    <= dd_next;
            pp_lo_reg <= PP_W'(rx40[HALF_W-1:0]) * PP_W'(par);
            pp_hi_reg <= PP_W'(rx40[mrc_pkg::PQ_W-1:HALF_W]) * PP_W'(par);
        end
        if (en2)
        begin
            side_reg <= side_next;
            den_reg  <= dd_reg;
            rem_reg  <= mrc_pkg::DD_W'(high);
            low_reg  <= {prod[mrc_pkg::MAG_W-17:0], 16'd0};
        end
    end

    assign in_ready  = en1;
    assign out_valid = s2_valid_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/mrc_back.sv -----
// Output stage: status priority, clamping, sign and the result register.
// Depends on mrc_pkg.
module mrc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mrc_pkg::MAG_W-1:0]       in_quo,
    input  mrc_pkg::solve_side_t            in_side,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mrc_pkg::MEAS_W-1:0]      measured_value,
    output logic [mrc_pkg::SUPPLY_W-1:0]    supply_voltage,
    output logic [mrc_pkg::RANGE_W-1:0]     range_code,
    output logic [mrc_pkg::STATUS_W-1:0]    status
);

    logic                           en;
    logic                           valid_reg;
    logic [mrc_pkg::MAG_W-1:0]      mag;
    logic                           neg;
    logic [mrc_pkg::SUPPLY_W-1:0]   sup;
    logic [mrc_pkg::STATUS_W-1:0]   st;
    logic [mrc_pkg::MEAS_W-1:0]     meas_next;
    logic [mrc_pkg::MEAS_W-1:0]     meas_reg;
    logic [mrc_pkg::SUPPLY_W-1:0]   sup_reg;
    logic [mrc_pkg::RANGE_W-1:0]    range_reg;
    logic [mrc_pkg::STATUS_W-1:0]   status_reg;

    assign en = !valid_reg || out_ready;

    always_comb
    begin
        mag = '0;
        neg = 1'b0;
        sup = '0;
        st  = mrc_pkg::ST_REFZERO;
        if (!in_side.mid.ref_zero)
        begin
            sup = in_side.mid.supply;
            st  = in_side.mid.sup_sat ? mrc_pkg::ST_SAT : mrc_pkg::ST_OK;
            if (in_side.mid.range <= mrc_pkg::RANGE_50V)
            begin
                mag = in_side.mid.vmag;
                neg = in_side.mid.neg;
                if (in_side.mid.vsat)
                begin
                    st = mrc_pkg::ST_SAT;
                end
            end
            else if (in_side.mid.pole)
            begin
                st = mrc_pkg::ST_OPEN;
            end
            else if (!in_side.dd_zero)
            begin
                neg = in_side.mid.neg;
                if (in_side.ovf)
                begin
                    mag = mrc_pkg::MAG_MAX;
                    st  = mrc_pkg::ST_SAT;
                end
                else
                begin
                    mag = in_quo;
                end
            end
        end
        meas_next = neg ? -{1'b0, mag} : {1'b0, mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meas_reg   <= meas_next;
            sup_reg    <= sup;
            range_reg  <= in_side.mid.range;
            status_reg <= st;
        end
    end

    assign in_ready       = en;
    assign out_valid      = valid_reg;
    assign measured_value = meas_reg;
    assign supply_voltage = sup_reg;
    assign range_code     = range_reg;
    assign status         = status_reg;

endmodule

// ----- rtl/multimeter_reading_convert_core.sv -----
// Stages in order: front, calibration divider, scaling, resistance divider, setup,
// parallel-removal divider and output.
// Throughput: one transaction per cycle while out_ready stays high; every stage holds
// its own valid bit and a stalled output only backs up stages that are occupied.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// Depends on mrc_pkg, mrc_front, mrc_div, mrc_mid, mrc_solve and mrc_back.
module multimeter_reading_convert_core #(
    parameter int ADC_BITS = mrc_pkg::ADC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrc_pkg::PADDR_W-1:0]     paddr,
    input  logic [mrc_pkg::PDATA_W-1:0]     pwdata,
    output logic [mrc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mrc_pkg::COUNT_W-1:0]     raw_input_count,
    input  logic [mrc_pkg::COUNT_W-1:0]     raw_reference_count,
    input  logic [mrc_pkg::COUNT_W-1:0]     raw_supply_count,
    input  logic [mrc_pkg::SW_W-1:0]        range_switches,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mrc_pkg::MEAS_W-1:0]      measured_value,
    output logic [mrc_pkg::SUPPLY_W-1:0]    supply_voltage,
    output logic [mrc_pkg::RANGE_W-1:0]     range_code,
    output logic [mrc_pkg::STATUS_W-1:0]    status
);

    localparam int CNT_W  = (ADC_BITS < mrc_pkg::COUNT_W) ? ADC_BITS : mrc_pkg::COUNT_W;
    localparam int VN_W   = CNT_W + mrc_pkg::VREF_W;
    localparam int SN_W   = VN_W + mrc_pkg::RATIO_W;
    localparam int FS_W   = $bits(mrc_pkg::front_side_t);
    localparam int MS_W   = $bits(mrc_pkg::mid_side_t);
    localparam int SS_W   = $bits(mrc_pkg::solve_side_t);

    logic [mrc_pkg::VREF_W-1:0]     vref_reg;
    logic [mrc_pkg::RATIO_W-1:0]    ratio_reg;
    logic [mrc_pkg::PAR_W-1:0]      par_reg;
    logic                           wr_en;

    logic                           f_valid, f_ready;
    logic [CNT_W-1:0]               f_den;
    logic [VN_W-1:0]                f_vnum;
    logic [SN_W-1:0]                f_snum;
    mrc_pkg::front_side_t           f_side;
    logic [1:0][SN_W-1:0]           d1_low;

    logic                           d1_valid, d1_ready;
    logic [1:0][SN_W-1:0]           d1_quo;
    logic [FS_W-1:0]                d1_side;

    logic                           m_valid, m_ready;
    logic [mrc_pkg::DEN2_W-1:0]     m_den;
    logic [mrc_pkg::RX_W-1:0]       m_num;
    mrc_pkg::mid_side_t             m_side;

    logic                           d2_valid, d2_ready;
    logic [0:0][mrc_pkg::RX_W-1:0]  d2_quo;
    logic [MS_W-1:0]                d2_side;

    logic                           s_valid, s_ready;
    logic [mrc_pkg::DD_W-1:0]       s_den;
    logic [mrc_pkg::DD_W-1:0]       s_rem;
    logic [mrc_pkg::MAG_W-1:0]      s_low;
    mrc_pkg::solve_side_t           s_side;

    logic                           d3_valid, d3_ready;
    logic [0:0][mrc_pkg::MAG_W-1:0] d3_quo;
    logic [SS_W-1:0]                d3_side;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_reg  <= mrc_pkg::VREF_RST;
            ratio_reg <= mrc_pkg::RATIO_RST;
            par_reg   <= mrc_pkg::PAR_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                mrc_pkg::REG_VREF:  vref_reg  <= pwdata[mrc_pkg::VREF_W-1:0];
                mrc_pkg::REG_RATIO: ratio_reg <= pwdata[mrc_pkg::RATIO_W-1:0];
                mrc_pkg::REG_PAR:   par_reg   <= pwdata[mrc_pkg::PAR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mrc_pkg::REG_VREF:  prdata = mrc_pkg::PDATA_W'(vref_reg);
            mrc_pkg::REG_RATIO: prdata = mrc_pkg::PDATA_W'(ratio_reg);
            mrc_pkg::REG_PAR:   prdata = mrc_pkg::PDATA_W'(par_reg);
            default:            prdata = '0;
        endcase
    end

    mrc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .raw_input_count     (raw_input_count),
        .raw_reference_count (raw_reference_count),
        .raw_supply_count    (raw_supply_count),
        .range_switches      (range_switches),
        .vref                (vref_reg),
        .ratio               (ratio_reg),
        .out_valid           (f_valid),
        .out_ready           (f_ready),
        .out_den             (f_den),
        .out_vnum            (f_vnum),
        .out_snum            (f_snum),
        .out_side            (f_side)
    );

    assign d1_low[0] = SN_W'(f_vnum);
    assign d1_low[1] = f_snum;

    mrc_div #(
        .LANES  (2),
        .DEN_W  (CNT_W),
        .QUO_W  (SN_W),
        .BPS    (mrc_pkg::DIV1_BPS),
        .SIDE_W (FS_W)
    ) u_div_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_den    (f_den),
        .in_rem    ('0),
        .in_low    (d1_low),
        .in_side   (f_side),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_side  (d1_side)
    );

    mrc_mid #(
        .ADC_BITS (ADC_BITS)
    ) u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_quo    (d1_quo),
        .in_side   (mrc_pkg::front_side_t'(d1_side)),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_den   (m_den),
        .out_num   (m_num),
        .out_side  (m_side)
    );

    mrc_div #(
        .LANES  (1),
        .DEN_W  (mrc_pkg::DEN2_W),
        .QUO_W  (mrc_pkg::RX_W),
        .BPS    (mrc_pkg::DIV2_BPS),
        .SIDE_W (MS_W)
    ) u_div_rx (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_valid),
        .in_ready  (m_ready),
        .in_den    (m_den),
        .in_rem    ('0),
        .in_low    (m_num),
        .in_side   (m_side),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_quo   (d2_quo),
        .out_side  (d2_side)
    );

    mrc_solve u_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_valid),
        .in_ready  (d2_ready),
        .in_rx     (d2_quo[0]),
        .in_side   (mrc_pkg::mid_side_t'(d2_side)),
        .par       (par_reg),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_den   (s_den),
        .out_rem   (s_rem),
        .out_low   (s_low),
        .out_side  (s_side)
    );

    mrc_div #(
        .LANES  (1),
        .DEN_W  (mrc_pkg::DD_W),
        .QUO_W  (mrc_pkg::MAG_W),
        .BPS    (mrc_pkg::DIV3_BPS),
        .SIDE_W (SS_W)
    ) u_div_par (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_den    (s_den),
        .in_rem    (s_rem),
        .in_low    (s_low),
        .in_side   (s_side),
        .out_valid (d3_valid),
        .out_ready (d3_ready),
        .out_quo   (d3_quo),
        .out_side  (d3_side)
    );

    mrc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (d3_valid),
        .in_ready       (d3_ready),
        .in_quo         (d3_quo[0]),
        .in_side        (mrc_pkg::solve_side_t'(d3_side)),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .measured_value (measured_value),
        .supply_voltage (supply_voltage),
        .range_code     (range_code),
        .status         (status)
    );

    a_refzero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mrc_pkg::ST_REFZERO |->
            measured_value == '0 && supply_voltage == '0)
        else $error("reference-zero transaction carries a nonzero value");

    a_open_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mrc_pkg::ST_OPEN |-> measured_value == '0)
        else $error("open or overrange transaction carries a nonzero value");

    a_open_only_ohms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (range_code == mrc_pkg::RANGE_2V || range_code == mrc_pkg::RANGE_10V ||
                      range_code == mrc_pkg::RANGE_50V) |-> status != mrc_pkg::ST_OPEN)
        else $error("voltage range reported an open divider");

endmodule
